FILE: rtl/gsa_pkg.sv
// Shared constants and elaboration-time helpers for the GELU/SiLU activation block.
// Holds the Q.30 constants and the logistic table point generator.
// No dependencies.
`default_nettype none
package gsa_pkg;

    // Default configuration
    localparam int DEF_DATA_WIDTH    = 16;
    localparam int DEF_FRAC_BITS     = 12;
    localparam int DEF_TABLE_ENTRIES = 256;

    // Q.30 constants
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
    localparam logic [30:0] GELU_K2  = 31'd1713444047;  // 2 * 0.7978845608
    localparam logic [25:0] GELU_C3  = 26'd48012366;    // 0.044715

    // Activation select codes
    localparam logic ACT_GELU = 1'b0;
    localparam logic ACT_SILU = 1'b1;

    // Shift-subtract long division, used only while building constants
    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Logistic table point k of n over [0, 8], Q.30: round(2^60 / (2^30 + e_k))
    function automatic logic [63:0] sig_point(input int k, input int n);
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] e_sum;
        logic [63:0] ratio;
        logic [63:0] e_k;
        logic [63:0] den;
        step  = long_div(64'd8 << 30, 64'(n));
        term  = 64'd1 << 30;
        e_sum = term;
        // exp(step) by a truncated Taylor series
        for (int i = 1; i <= 20; i++) begin
            term  = long_div((term * step) >> 30, 64'(i));
            e_sum = e_sum + term;
        end
        ratio = long_div((64'd1 << 60) + (e_sum >> 1), e_sum);
        e_k   = 64'd1 << 30;
        for (int i = 1; i <= k; i++) begin
            e_k = (e_k * ratio + (64'd1 << 29)) >> 30;
        end
        den = (64'd1 << 30) + e_k;
        return long_div((64'd1 << 60) + (den >> 1), den);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/gsa_arg.sv
// GELU argument pipeline: a = 2*0.79788*(m + 0.044715*m^3), four register stages.
// Depends on gsa_pkg for the Q.30 constants.
`default_nettype none
module gsa_arg #(
    parameter int FRAC_BITS = gsa_pkg::DEF_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [FRAC_BITS+1:0] i_mag,   // magnitude below 4.0
    output logic      [FRAC_BITS+3:0] o_arg    // registered
);
    import gsa_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int MGW = F + 2;
    localparam int SQW = F + 4;
    localparam int CUW = F + 6;
    localparam int INW = F + 3;
    localparam int AW  = F + 4;

    logic [SQW-1:0]    r_sq, n_sq;
    logic [CUW-1:0]    r_cu, n_cu;
    logic [INW-1:0]    r_in, n_in;
    logic [AW-1:0]     r_a,  n_a;
    logic [MGW-1:0]    r_mg2, r_mg3;
    logic [2*MGW-1:0]  w_sq_full;
    logic [SQW+MGW-1:0] w_cu_full;
    logic [CUW+25:0]   w_t_full;
    logic [INW+30:0]   w_a_full;

    // stage math
    always_comb begin
        w_sq_full = i_mag * i_mag;
        n_sq      = SQW'(w_sq_full >> F);
        w_cu_full = r_sq * r_mg2;
        n_cu      = CUW'(w_cu_full >> F);
        w_t_full  = r_cu * GELU_C3;
        n_in      = INW'(r_mg3) + INW'(w_t_full >> 30);
        w_a_full  = r_in * GELU_K2;
        n_a       = AW'(w_a_full >> 30);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq  <= n_sq;
            r_mg2 <= i_mag;
            r_cu  <= n_cu;
            r_mg3 <= r_mg2;
            r_in  <= n_in;
            r_a   <= n_a;
        end
    end

    assign o_arg = r_a;

endmodule
`default_nettype wire

FILE: rtl/gsa_sigma.sv
// Logistic lookup: table index, table read, interpolation, three register stages.
// Depends on gsa_pkg for the table generator and Q.30 constants.
`default_nettype none
module gsa_sigma #(
    parameter int FRAC_BITS     = gsa_pkg::DEF_FRAC_BITS,
    parameter int TABLE_ENTRIES = gsa_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [FRAC_BITS+2:0] i_q,     // magnitude below 8.0
    input  wire logic                 i_sat,   // argument at or beyond 8.0
    input  wire logic                 i_neg,   // argument negative
    output logic      [30:0]          o_sig    // Q.30, registered
);
    import gsa_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int QW  = F + 3;
    localparam int NW  = $clog2(TABLE_ENTRIES + 1);
    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int TW  = $clog2(TABLE_ENTRIES + 1);

    logic [30:0]     w_tab [TABLE_ENTRIES+1];
    logic [QW+NW-1:0] w_p;
    logic [IW-1:0]   r_idx;
    logic [QW-1:0]   r_fr1, r_fr2;
    logic [1:0]      r_flg1, r_flg2;   // {neg, sat}
    logic [30:0]     r_lo, r_hi;
    logic [30:0]     r_sig, n_sig;
    logic [TW-1:0]   w_ilo, w_ihi;
    logic [30:0]     w_diff;
    logic [QW+30:0]  w_prod;
    logic [31:0]     w_s;
    logic [30:0]     w_sc;

    // constant table of logistic points
    for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_tab
        assign w_tab[k] = 31'(sig_point(k, TABLE_ENTRIES));
    end

    assign w_p   = i_q * NW'(TABLE_ENTRIES);
    assign w_ilo = TW'(r_idx);
    assign w_ihi = TW'(r_idx) + TW'(1);

    // stage 1: index and fraction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx  <= IW'(w_p >> QW);
            r_fr1  <= w_p[QW-1:0];
            r_flg1 <= {i_neg, i_sat};
        end
    end

    // stage 2: table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo   <= w_tab[w_ilo];
            r_hi   <= w_tab[w_ihi];
            r_fr2  <= r_fr1;
            r_flg2 <= r_flg1;
        end
    end

    // stage 3: interpolate, clamp, reflect for negative arguments
    always_comb begin
        w_diff = (r_hi > r_lo) ? (r_hi - r_lo) : '0;
        w_prod = w_diff * r_fr2;
        w_s    = 32'(r_lo) + 32'(w_prod >> QW);
        w_sc   = (r_flg2[0] || w_s > 32'(ONE_Q30)) ? ONE_Q30 : w_s[30:0];
        n_sig  = r_flg2[1] ? (ONE_Q30 - w_sc) : w_sc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sig <= n_sig;
        end
    end

    assign o_sig = r_sig;

endmodule
`default_nettype wire

FILE: rtl/gelu_silu_activation.sv
// GELU (tanh form) / SiLU activation, y = x * sigma(a), signed fixed point.
// Throughput one sample per cycle while the output side does not stall, set by the
// fully pipelined argument and lookup stages.
// A stall on the output side freezes the whole pipeline; nothing is dropped.
// Reset (synchronous, active low) clears valid bits and selects GELU.
`default_nettype none
module gelu_silu_activation #(
    parameter int DATA_WIDTH    = gsa_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS     = gsa_pkg::DEF_FRAC_BITS,
    parameter int TABLE_ENTRIES = gsa_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration: act_type (0 GELU, 1 SiLU)
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic                                i_cfg_data,
    // input stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     i_s_tdata,  // [W-1:0] x_sample
    // output stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic      [((DATA_WIDTH+7)/8)*8-1:0]     o_m_tdata   // [W-1:0] y_sample
);
    import gsa_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int BW  = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int LAT = 10;
    localparam int AW  = F + 4;
    localparam int QW  = F + 3;

    logic           r_act;
    logic           w_en;
    logic [LAT:1]   r_v;
    logic [W-1:0]   r_mag [1:9];
    logic           r_neg [1:9];
    logic           r_act_s [1:5];
    logic           r_big [1:5];
    logic [F+1:0]   r_mg;
    logic [W-1:0]   w_x;
    logic [W-1:0]   w_mag;
    logic           w_big;
    logic [AW-1:0]  w_arg;
    logic [QW-1:0]  r_q, n_q;
    logic           r_sat, n_sat;
    logic           r_aneg;
    logic [30:0]    w_sig;
    logic [W+31:0]  w_ymp;
    logic [W:0]     w_ym;
    logic [W-1:0]   r_y, n_y;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= ACT_GELU;
        end else if (i_cfg_valid) begin
            r_act <= i_cfg_data;
        end
    end

    // pipeline advance: last stage empty or being taken
    assign w_en       = !r_v[LAT] || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[LAT-1:1], i_s_tvalid};
        end
    end

    // stage 1: sign and magnitude
    assign w_x   = i_s_tdata[W-1:0];
    assign w_mag = w_x[W-1] ? (W'(0) - w_x) : w_x;
    assign w_big = 64'(w_mag) >= (64'd4 << F);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag[1]   <= w_mag;
            r_neg[1]   <= w_x[W-1];
            r_act_s[1] <= r_act;
            r_big[1]   <= w_big;
            r_mg       <= w_big ? '0 : (F+2)'(w_mag);
            for (int i = 2; i <= 9; i++) begin
                r_mag[i] <= r_mag[i-1];
                r_neg[i] <= r_neg[i-1];
            end
            for (int i = 2; i <= 5; i++) begin
                r_act_s[i] <= r_act_s[i-1];
                r_big[i]   <= r_big[i-1];
            end
        end
    end

    // stages 2..5: GELU argument
    gsa_arg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arg (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (r_mg),
        .o_arg (w_arg)
    );

    // stage 6: pick the logistic argument, flag saturation
    always_comb begin
        if (r_act_s[5] == ACT_SILU) begin
            n_sat = 64'(r_mag[5]) >= (64'd8 << F);
            n_q   = QW'(r_mag[5]);
        end else begin
            n_sat = r_big[5] || (64'(w_arg) >= (64'd8 << F));
            n_q   = QW'(w_arg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q    <= n_q;
            r_sat  <= n_sat;
            r_aneg <= r_neg[5];
        end
    end

    // stages 7..9: logistic lookup
    gsa_sigma #(
        .FRAC_BITS     (FRAC_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_sigma (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_q   (r_q),
        .i_sat (r_sat),
        .i_neg (r_aneg),
        .o_sig (w_sig)
    );

    // stage 10: scale, round half away from zero, saturate
    always_comb begin
        w_ymp = (W+32)'(r_mag[9]) * (W+32)'(w_sig) + (W+32)'(HALF_Q30);
        w_ym  = (W+1)'(w_ymp >> 30);
        if (r_neg[9]) begin
            if (w_ym > ((W+1)'(1) << (W-1))) begin
                n_y = {1'b1, {(W-1){1'b0}}};
            end else begin
                n_y = W'((W+1)'(0) - w_ym);
            end
        end else begin
            if (w_ym > (((W+1)'(1) << (W-1)) - (W+1)'(1))) begin
                n_y = {1'b0, {(W-1){1'b1}}};
            end else begin
                n_y = W'(w_ym);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y <= n_y;
        end
    end

    assign o_m_tvalid = r_v[LAT];
    assign o_m_tdata  = BW'(r_y);

endmodule
`default_nettype wire
